### hw/rtl/sha1bc_pkg.sv
// Shared types, constants and helper functions for the SHA-1 block compression unit.
// Used by sha1bc_front, sha1bc_core and sha1_block_compress_unit; has no dependencies.
package sha1bc_pkg;

    // Stream widths: fields packed from bit 0 up, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam int WORD_W  = 32;
    localparam int INDEX_W = 3;

    // Chaining value and message block geometry
    localparam int CV_WORDS   = 5;
    localparam int BLK_WORDS  = 16;
    localparam int NUM_ROUNDS = 80;

    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(CV_WORDS - 1);
    localparam logic [3:0]         LAST_MSG   = 4'(BLK_WORDS - 1);
    localparam logic [6:0]         LAST_ROUND = 7'(NUM_ROUNDS - 1);

    // Command queue between front and core
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = 1;

    // Round constants, one per group of twenty rounds
    localparam logic [WORD_W-1:0] K_CH  = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_P1  = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_P2  = 32'hCA62C1D6;

    // What a queued command asks the core to do
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_MSG  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [INDEX_W-1:0]   idx;
        logic [WORD_W-1:0]    word;
    } cmd_t;

    // Head of the command queue as seen by the core
    typedef struct packed {
        logic avail;
        cmd_t cmd;
    } cmdq_head_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } core_state_t;

    function automatic logic [WORD_W-1:0] rotl1(input logic [WORD_W-1:0] v);
        rotl1 = {v[WORD_W-2:0], v[WORD_W-1]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl5(input logic [WORD_W-1:0] v);
        rotl5 = {v[WORD_W-6:0], v[WORD_W-1:WORD_W-5]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl30(input logic [WORD_W-1:0] v);
        rotl30 = {v[1:0], v[WORD_W-1:2]};
    endfunction

endpackage

### hw/rtl/sha1bc_front.sv
// Front end: takes input transfers, drops loads of non-existent chaining words,
// and queues the rest for the core. Depends on sha1bc_pkg.
module sha1bc_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sha1bc_pkg::S_TDATA_W-1:0]   s_tdata,  // [2:0] chain_index, [34:3] data_word
    input  logic                               s_tuser,  // [0] func
    output sha1bc_pkg::cmdq_head_t             head,
    input  logic                               pop
);
    import sha1bc_pkg::*;

    cmd_t                 q_mem_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_AW:0]     count_reg, count_next;

    cmd_t in_cmd;
    logic drop;
    logic push;

    // Classify the incoming transfer
    always_comb
    begin
        in_cmd.kind = cmd_kind_t'(s_tuser);
        in_cmd.idx  = s_tdata[INDEX_W-1:0];
        in_cmd.word = s_tdata[INDEX_W+WORD_W-1:INDEX_W];
        drop        = (in_cmd.kind == CMD_LOAD) && (in_cmd.idx > LAST_INDEX);
    end

    assign s_tready = (count_reg != (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign push     = s_tvalid && s_tready && !drop;

    // Queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assign head.avail = (count_reg != '0);
    assign head.cmd   = q_mem_reg[rd_ptr_reg];

endmodule

### hw/rtl/sha1bc_core.sv
// Back end: chaining value, message window, 80-round engine and result register.
// Depends on sha1bc_pkg; fed by sha1bc_front through the command queue.
module sha1bc_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sha1bc_pkg::cmdq_head_t             head,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sha1bc_pkg::M_TDATA_W-1:0]   m_tdata,  // [2:0] hash_index, [34:3] hash_word
    output logic                               m_tlast   // last_word
);
    import sha1bc_pkg::*;

    core_state_t state_reg, state_next;

    logic [WORD_W-1:0]  cv_reg  [CV_WORDS];
    logic [WORD_W-1:0]  win_reg [BLK_WORDS];
    logic [WORD_W-1:0]  a_reg, b_reg, c_reg, d_reg, e_reg;

    logic [3:0]         cnt_reg, cnt_next;
    logic [6:0]         round_reg, round_next;
    logic [INDEX_W-1:0] emit_idx_reg, emit_idx_next;

    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_idx_reg;
    logic [WORD_W-1:0]  out_word_reg;
    logic               out_last_reg;

    logic               is_msg, is_load, block_done, out_load;
    logic [WORD_W-1:0]  f_val, k_val, t_val, w_new;

    // Decode of the queue head and handshake of the result register
    always_comb
    begin
        pop        = (state_reg == ST_IDLE) && head.avail;
        is_msg     = pop && (head.cmd.kind == CMD_MSG);
        is_load    = pop && (head.cmd.kind == CMD_LOAD);
        block_done = is_msg && (cnt_reg == LAST_MSG);
        out_load   = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (block_done)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load && (emit_idx_reg == LAST_INDEX))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Counters and result valid
    always_comb
    begin
        cnt_next       = cnt_reg;
        round_next     = round_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                round_next = '0;
                if (is_msg)
                begin
                    cnt_next = block_done ? 4'd0 : cnt_reg + 4'd1;
                end
            end
            ST_ROUND:
            begin
                round_next = round_reg + 7'd1;
            end
            ST_FINAL:
            begin
                emit_idx_next = '0;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    emit_idx_next  = emit_idx_reg + 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                round_next = '0;
            end
        endcase
    end

    // Round function, constant and new schedule word
    always_comb
    begin
        priority if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_CH;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_P1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_MAJ;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_P2;
        end
        t_val = rotl5(a_reg) + f_val + e_reg + win_reg[0] + k_val;
        w_new = rotl1(win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0]);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            round_reg     <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            round_reg     <= round_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Chaining value: loads and the final feed-forward add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CV_WORDS; i++)
            begin
                cv_reg[i] <= '0;
            end
        end
        else if (is_load)
        begin
            cv_reg[head.cmd.idx] <= head.cmd.word;
        end
        else if (state_reg == ST_FINAL)
        begin
            cv_reg[0] <= cv_reg[0] + a_reg;
            cv_reg[1] <= cv_reg[1] + b_reg;
            cv_reg[2] <= cv_reg[2] + c_reg;
            cv_reg[3] <= cv_reg[3] + d_reg;
            cv_reg[4] <= cv_reg[4] + e_reg;
        end
    end

    // Message window: words shift in, rounds shift the expanded schedule through
    always_ff @(posedge clk)
    begin
        if (is_msg || (state_reg == ST_ROUND))
        begin
            for (int i = 0; i < BLK_WORDS - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[BLK_WORDS-1] <= is_msg ? head.cmd.word : w_new;
        end
    end

    // Working variables
    always_ff @(posedge clk)
    begin
        if (block_done)
        begin
            a_reg <= cv_reg[0];
            b_reg <= cv_reg[1];
            c_reg <= cv_reg[2];
            d_reg <= cv_reg[3];
            e_reg <= cv_reg[4];
        end
        else if (state_reg == ST_ROUND)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= rotl30(b_reg);
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_idx_reg  <= emit_idx_reg;
            out_word_reg <= cv_reg[emit_idx_reg];
            out_last_reg <= (emit_idx_reg == LAST_INDEX);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W-WORD_W-INDEX_W)'(0), out_word_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

### hw/rtl/sha1_block_compress_unit.sv
// SHA-1 block compression unit: loads, message words in, five chaining words out.
// Flow: each load or message word passes through the command queue into the core; the sixteenth
// message word starts the round engine, then the feed-forward add, then the five results leave
// through the result register in index order. The core takes no new words until the last result
// is loaded into the result register, so blocks do not overlap in the single round engine.
// The two-entry command queue keeps accepting while the core is busy, until it fills.
// Reset: rst_n asynchronous, active low; clears chaining value, word count, queue and result valid.
module sha1_block_compress_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sha1bc_pkg::S_TDATA_W-1:0]   s_tdata,  // [2:0] chain_index, [34:3] data_word
    input  logic                               s_tuser,  // [0] func
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sha1bc_pkg::M_TDATA_W-1:0]   m_tdata,  // [2:0] hash_index, [34:3] hash_word
    output logic                               m_tlast
);
    import sha1bc_pkg::*;

    cmdq_head_t cmd_head;
    logic       cmd_pop;

    sha1bc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (cmd_head),
        .pop      (cmd_pop)
    );

    sha1bc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (cmd_head),
        .pop      (cmd_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The core only takes commands the queue actually holds
    a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_head.avail)
        else $error("command popped from empty queue");

    // Last marker only on the final chaining word
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[INDEX_W-1:0] == LAST_INDEX)))
        else $error("tlast does not match hash index");

    // Consecutive results count up through the chaining words
    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid
            |-> m_tdata[INDEX_W-1:0] == $past(m_tdata[INDEX_W-1:0]) + 1'b1)
        else $error("hash index out of order");

endmodule

### sim/testbench.sv
// Self-checking testbench for sha1_block_compress_unit: drives loads and message words,
// predicts every updated chaining word and checks the result stream as it leaves the block.
// Depends on hw/rtl/sha1bc_pkg.sv and hw/rtl/sha1_block_compress_unit.sv.
`timescale 1ns / 100ps

module testbench;
    import sha1bc_pkg::*;

    localparam int RANDOM_ITEMS    = 436;   // counted loads and message words after the directed part
    localparam int WATCHDOG_LIMIT  = 3000;  // cycles without any transfer on either side
    localparam int DRAIN_CYCLES    = 150;   // round engine latency plus some margin

    // One input transfer
    typedef struct packed {
        cmd_kind_t            func;
        logic [INDEX_W-1:0]   chain_index;
        logic [WORD_W-1:0]    data_word;
    } sha_item_t;

    // One updated chaining word
    typedef struct packed {
        logic [INDEX_W-1:0]   hash_index;
        logic [WORD_W-1:0]    hash_word;
        logic                 last_word;
    } hash_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    sha_item_t      pending_items[$];
    hash_result_t   expected_hash_q[$];

    // Predictor state
    logic [WORD_W-1:0]  chain_val[CV_WORDS];
    logic [WORD_W-1:0]  msg_buf[BLK_WORDS];
    logic [3:0]         msg_count = '0;

    int     counted_items = 0;
    int     mismatch_count = 0;
    int     idle_cycles = 0;
    int     s_gap_left = 0;
    int     s_calm = 0;
    int     m_stall_left = 0;
    int     m_calm = 0;
    logic   s_xfer = 1'b0;

    sha1_block_compress_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [WORD_W-1:0] rol32(input logic [WORD_W-1:0] v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // Full SHA-1 compression of the buffered block into the predicted chaining value
    function automatic void compress_into_chain();
        logic [WORD_W-1:0] w[80];
        logic [WORD_W-1:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 80; r++)
        begin
            if (r < BLK_WORDS)
                w[r] = msg_buf[r];
            else
                w[r] = rol32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        end
        a = chain_val[0];
        b = chain_val[1];
        c = chain_val[2];
        d = chain_val[3];
        e = chain_val[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K_P1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_P2;
            end
            t = rol32(a, 5) + f + e + w[r] + k;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chain_val[0] += a;
        chain_val[1] += b;
        chain_val[2] += c;
        chain_val[3] += d;
        chain_val[4] += e;
    endfunction

    // Update predictor with one accepted transfer; queue the five words on a block end
    function automatic void predict_hash_words(input sha_item_t it);
        hash_result_t res;
        if (it.func == CMD_LOAD)
        begin
            if (it.chain_index < CV_WORDS)
                chain_val[it.chain_index] = it.data_word;
        end
        else
        begin
            msg_buf[msg_count] = it.data_word;
            if (msg_count == LAST_MSG)
            begin
                msg_count = '0;
                compress_into_chain();
                for (int i = 0; i < CV_WORDS; i++)
                begin
                    res.hash_index = INDEX_W'(i);
                    res.hash_word  = chain_val[i];
                    res.last_word  = (i == CV_WORDS - 1);
                    expected_hash_q.push_back(res);
                end
            end
            else
                msg_count++;
        end
    endfunction

    function automatic void queue_item(input cmd_kind_t func, input int idx,
                                       input logic [WORD_W-1:0] data);
        sha_item_t it;
        it.func        = func;
        it.chain_index = INDEX_W'(idx);
        it.data_word   = data;
        pending_items.push_back(it);
        if (func == CMD_MSG || idx < CV_WORDS)
            counted_items++;
    endfunction

    // Mostly random words, with the all-zeros and all-ones extremes now and then
    function automatic logic [WORD_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // Idle length: mostly none or short, a few long, with calm stretches of no idling
    function automatic int draw_gap(ref int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sender: next item or idle at the falling edge once the current transfer is done
    always @(negedge clk)
    begin
        sha_item_t it;
        if (rst_n && (!s_tvalid || s_xfer))
        begin
            if (s_gap_left > 0)
            begin
                s_gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_TDATA_W - WORD_W - INDEX_W){1'b0}}, it.data_word, it.chain_index};
                s_tuser  <= it.func;
                s_gap_left = draw_gap(s_calm);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls on m_tready
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_stall_left == 0 && $urandom_range(0, 3) == 0)
                m_stall_left = draw_gap(m_calm);
            if (m_stall_left > 0)
            begin
                m_stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: predict on input transfers, check output transfers, watchdog
    always @(posedge clk)
    begin
        hash_result_t exp_res;
        sha_item_t    it;
        logic         in_xfer;
        logic         out_xfer;
        in_xfer  = rst_n && s_tvalid && s_tready;
        out_xfer = rst_n && m_tvalid && m_tready;
        s_xfer <= in_xfer;

        if (out_xfer)
        begin
            if (expected_hash_q.size() == 0)
            begin
                $error("unexpected result: hash_index %0d, hash_word %h",
                       m_tdata[INDEX_W-1:0], m_tdata[INDEX_W +: WORD_W]);
                mismatch_count++;
            end
            else
            begin
                exp_res = expected_hash_q.pop_front();
                if (m_tdata[INDEX_W-1:0] !== exp_res.hash_index)
                begin
                    $error("hash_index: expected %0d, actual %0d",
                           exp_res.hash_index, m_tdata[INDEX_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[INDEX_W +: WORD_W] !== exp_res.hash_word)
                begin
                    $error("hash_word: expected %h, actual %h",
                           exp_res.hash_word, m_tdata[INDEX_W +: WORD_W]);
                    mismatch_count++;
                end
                if (m_tlast !== exp_res.last_word)
                begin
                    $error("last_word: expected %b, actual %b", exp_res.last_word, m_tlast);
                    mismatch_count++;
                end
            end
        end

        if (in_xfer)
        begin
            it.func        = cmd_kind_t'(s_tuser);
            it.chain_index = s_tdata[INDEX_W-1:0];
            it.data_word   = s_tdata[INDEX_W +: WORD_W];
            predict_hash_words(it);
        end

        if (rst_n)
        begin
            if (in_xfer || out_xfer)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        logic [WORD_W-1:0] abc_block[BLK_WORDS];
        int target;

        for (int i = 0; i < CV_WORDS; i++)
            chain_val[i] = '0;
        for (int i = 0; i < BLK_WORDS; i++)
            abc_block[i] = '0;
        abc_block[0]  = 32'h61626380;
        abc_block[15] = 32'h00000018;

        // Directed: standard initial value with a load in mid-block, ignored loads,
        // message words whose non-zero index must be ignored
        queue_item(CMD_LOAD, 0, 32'h67452301);
        queue_item(CMD_LOAD, 1, 32'hEFCDAB89);
        queue_item(CMD_LOAD, 2, 32'h98BADCFE);
        queue_item(CMD_LOAD, 3, 32'h10325476);
        for (int i = 0; i < 8; i++)
            queue_item(CMD_MSG, (i == 3) ? 7 : 0, abc_block[i]);
        queue_item(CMD_LOAD, 4, 32'hC3D2E1F0);
        queue_item(CMD_LOAD, 5, '1);
        queue_item(CMD_LOAD, 6, '1);
        queue_item(CMD_LOAD, 7, '1);
        for (int i = 8; i < BLK_WORDS; i++)
            queue_item(CMD_MSG, (i == 15) ? 5 : 0, abc_block[i]);

        // Random: whole blocks, occasional chain reloads and stray loads between words
        target = counted_items + RANDOM_ITEMS;
        while (counted_items < target)
        begin
            if ($urandom_range(0, 3) == 0)
                for (int i = 0; i < CV_WORDS; i++)
                    queue_item(CMD_LOAD, i, rand_word());
            for (int i = 0; i < BLK_WORDS; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    queue_item(CMD_LOAD, $urandom_range(0, 7), rand_word());
                queue_item(CMD_MSG, $urandom_range(0, 7), rand_word());
            end
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_hash_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
